// ----- src/slte_pkg.sv -----
// ----------------------------------------------------------------------------
// slte_pkg: shared types and constants of the sprite list tile expander
// Payload structs, command/status bundles, controller states and the fixed
// coordinate constants used by the sprite list decode.
// ----------------------------------------------------------------------------
package slte_pkg;

   // default geometry
   localparam int BORDER_PIXELS_DEF  = 16;
   localparam int VISIBLE_WIDTH_DEF  = 320;
   localparam int VISIBLE_HEIGHT_DEF = 240;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPRITE_X_OFFSET = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPRITE_Y_OFFSET = 2'd1;
   localparam logic signed [CSR_DATA_WIDTH-1:0] X_OFFSET_RESET = -5'sd4;
   localparam logic signed [CSR_DATA_WIDTH-1:0] Y_OFFSET_RESET = 5'sd0;

   // signed working width of screen coordinates
   localparam int COORD_WIDTH = 12;
   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   // attribute decode constants
   localparam int X_WRAP_LIMIT = 320;
   localparam int Y_WRAP_LIMIT = 256;
   localparam int WRAP_SPAN    = 512;
   localparam int X_MIRROR     = 304;
   localparam int Y_MIRROR     = 240;
   localparam int TILE_SIZE    = 16;
   localparam int Y_ALIGN      = 7;

   // attribute-y bit positions
   localparam int AY_FLASH_BIT = 12;
   localparam int AY_FLIPX_BIT = 13;
   localparam int AY_FLIPY_BIT = 14;

   typedef struct packed {
      logic        start_of_list;
      logic [15:0] attr_y_word;
      logic [15:0] code_word;
      logic [15:0] attr_x_word;
   } req_type;

   typedef struct packed {
      logic [15:0] tile_code;
      logic [8:0]  screen_x;
      logic [7:0]  screen_y;
      logic [3:0]  colour;
      logic [1:0]  flip;
      logic        last;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;   // latch the accepted entry
      logic calc;   // decode the entry and set up the tile walk
      logic step;   // move to the next tile
      logic emit;   // write the current tile into the output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic drop;      // entry gives no tiles
      logic tile_vis;  // current tile is vertically visible
      logic final_k;   // current tile is the bottom one
      logic out_free;  // output register can take a tile
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_EMIT
   } state_type;

endpackage

// ----- src/slte_ctrl.sv -----
// ----------------------------------------------------------------------------
// slte_ctrl: sequencing state machine
// Accepts one entry, runs the decode cycle, then walks the tiles top down.
// ----------------------------------------------------------------------------
module slte_ctrl
   import slte_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CALC;
         end
         ST_CALC: begin
            state_in = status.drop ? ST_IDLE : ST_EMIT;
         end
         ST_EMIT: begin
            if ((!status.tile_vis || status.out_free) && status.final_k) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
         end
         ST_EMIT: begin
            cmd.step = !status.tile_vis || status.out_free;
            cmd.emit = status.tile_vis && status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ----- src/slte_datapath.sv -----
// ----------------------------------------------------------------------------
// slte_datapath: entry decode, tile walk and output register
// Holds the offsets, the frame parity, the latched entry, the per-tile
// position and code, and the registered result.
// ----------------------------------------------------------------------------
module slte_datapath
   import slte_pkg::*;
#(
   parameter int BORDER_PIXELS  = BORDER_PIXELS_DEF,
   parameter int VISIBLE_WIDTH  = VISIBLE_WIDTH_DEF,
   parameter int VISIBLE_HEIGHT = VISIBLE_HEIGHT_DEF
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   input  req_type                    req_data,
   input  cmd_type                    cmd,
   output status_type                 status,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_type                    rsp_data
);

   localparam coord_type X_LOW  = coord_type'(BORDER_PIXELS - TILE_SIZE);
   localparam coord_type X_HIGH = coord_type'(VISIBLE_WIDTH + BORDER_PIXELS);
   localparam coord_type Y_LOW  = coord_type'(BORDER_PIXELS - TILE_SIZE);
   localparam coord_type Y_HIGH = coord_type'(VISIBLE_HEIGHT + BORDER_PIXELS);

   logic signed [CSR_DATA_WIDTH-1:0] x_offset_ff, x_offset_in;
   logic signed [CSR_DATA_WIDTH-1:0] y_offset_ff, y_offset_in;
   logic        parity_ff, parity_in;
   logic [15:0] ay_ff, ay_in;
   logic [15:0] code_ff, code_in;
   logic [15:0] ax_ff, ax_in;
   logic [8:0]  xdraw_ff, xdraw_in;
   coord_type   ydraw_ff, ydraw_in;
   logic [15:0] tile_ff, tile_in;
   logic [2:0]  k_ff, k_in;
   logic [2:0]  count_m1_ff, count_m1_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic [2:0]  count_m1;
   logic [8:0]  x9, y9;
   coord_type   x_wrap, y_wrap, xdraw, ydraw_top, ydraw_next;
   logic        drop_x, next_vis;

   // configuration registers
   always_comb begin
      x_offset_in = x_offset_ff;
      y_offset_in = y_offset_ff;
      if (csr_write_en && csr_index == CSR_SPRITE_X_OFFSET) x_offset_in = csr_data;
      if (csr_write_en && csr_index == CSR_SPRITE_Y_OFFSET) y_offset_in = csr_data;
   end

   // entry latch and frame parity
   always_comb begin
      parity_in = parity_ff;
      ay_in     = ay_ff;
      code_in   = code_ff;
      ax_in     = ax_ff;
      if (cmd.load) begin
         parity_in = parity_ff ^ req_data.start_of_list;
         ay_in     = req_data.attr_y_word;
         code_in   = req_data.code_word;
         ax_in     = req_data.attr_x_word;
      end
   end

   // height code to tile count minus one
   always_comb begin
      unique case (ay_ff[10:9])
         2'd0:    count_m1 = 3'd0;
         2'd1:    count_m1 = 3'd1;
         2'd2:    count_m1 = 3'd3;
         default: count_m1 = 3'd7;
      endcase
   end

   // coordinate wrap, mirror and offsets
   assign x9 = ax_ff[8:0];
   assign y9 = ay_ff[8:0];
   assign x_wrap = (x9 >= 9'(X_WRAP_LIMIT))
                 ? coord_type'({3'b000, x9}) - coord_type'(WRAP_SPAN)
                 : coord_type'({3'b000, x9});
   assign y_wrap = (y9 >= 9'(Y_WRAP_LIMIT))
                 ? coord_type'({3'b000, y9}) - coord_type'(WRAP_SPAN)
                 : coord_type'({3'b000, y9});
   assign xdraw = coord_type'(X_MIRROR) - x_wrap + coord_type'(BORDER_PIXELS)
                + coord_type'(x_offset_ff);
   assign ydraw_top = coord_type'(Y_MIRROR) - y_wrap - coord_type'({count_m1, 4'b0000})
                    + coord_type'(BORDER_PIXELS - Y_ALIGN) + coord_type'(y_offset_ff);
   assign drop_x = (xdraw <= X_LOW) || (xdraw >= X_HIGH);

   // vertical visibility of this tile and the one below
   assign ydraw_next = ydraw_ff + coord_type'(TILE_SIZE);
   assign next_vis   = (ydraw_next > Y_LOW) && (ydraw_next < Y_HIGH);

   assign status.drop     = (code_ff == 16'h0000) || (ay_ff[AY_FLASH_BIT] && parity_ff) || drop_x;
   assign status.tile_vis = (ydraw_ff > Y_LOW) && (ydraw_ff < Y_HIGH);
   assign status.final_k  = (k_ff == count_m1_ff);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // tile walk
   always_comb begin
      xdraw_in    = xdraw_ff;
      ydraw_in    = ydraw_ff;
      tile_in     = tile_ff;
      k_in        = k_ff;
      count_m1_in = count_m1_ff;
      if (cmd.calc) begin
         xdraw_in    = xdraw[8:0];
         ydraw_in    = ydraw_top;
         k_in        = 3'd0;
         count_m1_in = count_m1;
         tile_in     = ay_ff[AY_FLIPY_BIT] ? code_ff + {13'd0, count_m1} : code_ff;
      end else if (cmd.step) begin
         ydraw_in = ydraw_next;
         k_in     = k_ff + 3'd1;
         tile_in  = ay_ff[AY_FLIPY_BIT] ? tile_ff - 16'd1 : tile_ff + 16'd1;
      end
   end

   // output register
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.emit) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.tile_code = tile_ff;
         rsp_data_in.screen_x  = xdraw_ff;
         rsp_data_in.screen_y  = ydraw_ff[7:0];
         rsp_data_in.colour    = ax_ff[12:9];
         rsp_data_in.flip      = {ay_ff[AY_FLIPY_BIT], ay_ff[AY_FLIPX_BIT]};
         rsp_data_in.last      = status.final_k || !next_vis;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_offset_ff  <= X_OFFSET_RESET;
         y_offset_ff  <= Y_OFFSET_RESET;
         parity_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         x_offset_ff  <= x_offset_in;
         y_offset_ff  <= y_offset_in;
         parity_ff    <= parity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ay_ff       <= ay_in;
      code_ff     <= code_in;
      ax_ff       <= ax_in;
      xdraw_ff    <= xdraw_in;
      ydraw_ff    <= ydraw_in;
      tile_ff     <= tile_in;
      k_ff        <= k_in;
      count_m1_ff <= count_m1_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- src/sprite_list_tile_expander.sv -----
// ----------------------------------------------------------------------------
// sprite_list_tile_expander: sprite list entry to tile draw commands
// Expands one sprite list entry into up to eight 16x16 tile commands.
// ----------------------------------------------------------------------------
// One entry is taken at a time. It is accepted in the idle state, decoded in
// the next, and then walks its 1, 2, 4 or 8 tiles one per cycle through the
// tile-walk counter when results are taken at once; a dropped entry returns
// to idle after its decode. Stalls on the result side pause the walk on
// visible tiles. A finished tile waits in the output register while the walk
// moves on. Offsets are written through the csr port while the block is idle;
// the user is bound to this, as the block itself does not enforce it.
module sprite_list_tile_expander
   import slte_pkg::*;
#(
   parameter int BORDER_PIXELS  = BORDER_PIXELS_DEF,
   parameter int VISIBLE_WIDTH  = VISIBLE_WIDTH_DEF,
   parameter int VISIBLE_HEIGHT = VISIBLE_HEIGHT_DEF
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_type                    rsp_data
);

   cmd_type    cmd;
   status_type status;

   // sequencing
   slte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // decode and tile walk
   slte_datapath #(
      .BORDER_PIXELS  (BORDER_PIXELS),
      .VISIBLE_WIDTH  (VISIBLE_WIDTH),
      .VISIBLE_HEIGHT (VISIBLE_HEIGHT)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_data     (req_data),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

   // a tile is never written over a transaction that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid || rsp_ready))
      else $error("output register overwritten");

   // one entry in flight: no new transaction right after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("entry accepted while busy");

   // nothing follows the bottom tile within the same entry
   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && status.final_k) |=> (!cmd.emit && req_ready))
      else $error("tile emitted after the bottom tile");

   // the walk only runs after a decode that kept the entry
   assert property (@(posedge clock) disable iff (reset)
      (cmd.calc && status.drop) |=> (!cmd.step && req_ready))
      else $error("dropped entry produced tiles");

endmodule

// ----- test/sprite_list_tile_expander_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sprite_list_tile_expander_test: self-checking bench for the tile expander
// Sends sprite list entries through the request channel and predicts the
// tile draw commands of each accepted entry: frame parity, flashing, wrap,
// mirror, offsets and both clips. Draw commands are checked in order against
// the prediction while both channels idle at random. Offsets are changed
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module sprite_list_tile_expander_test;
   import slte_pkg::*;

   localparam int          BORDER        = BORDER_PIXELS_DEF;
   localparam int          VIS_W         = VISIBLE_WIDTH_DEF;
   localparam int          VIS_H         = VISIBLE_HEIGHT_DEF;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned SETTLE_CYCLES = 16;
   localparam int unsigned REPORT_LIMIT  = 10;

   // register indexes with no register behind them
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_3 = 2'd3;

   typedef enum logic [1:0] {HEIGHT_1, HEIGHT_2, HEIGHT_4, HEIGHT_8} height_code_type;
   typedef enum logic [1:0] {FLIP_NONE, FLIP_X, FLIP_Y, FLIP_XY} flip_type;

   typedef struct {
      req_type     entry;
      int unsigned gap;
      bit          drain_first;
   } entry_slot_type;

   logic                       clock        = 1'b0;
   logic                       reset        = 1'b1;
   logic                       csr_write_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index    = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data     = '0;
   logic                       req_valid    = 1'b0;
   logic                       req_ready;
   req_type                    req_data     = '0;
   logic                       rsp_valid;
   logic                       rsp_ready    = 1'b0;
   rsp_type                    rsp_data;

   // offsets and frame parity as the block should hold them
   int          x_shift = X_OFFSET_RESET;
   int          y_shift = Y_OFFSET_RESET;
   bit          odd_frame;
   bit          gen_odd_frame;

   entry_slot_type pending_entries[$];
   rsp_type        tile_cmds_due[$];
   entry_slot_type staged_slot;
   bit          staged;
   int unsigned hold_left;
   int unsigned stall_left;
   int unsigned source_calm;
   int unsigned sink_calm;
   int unsigned entries_queued;
   int unsigned entries_taken;
   int unsigned error_count;
   int unsigned cycle_count;

   sprite_list_tile_expander DUT (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

   always #1 clock = ~clock;

   // tile commands of one entry; pushed onto the expected queue when commit is set
   function automatic int expand_entry(input req_type e, input bit odd, input bit commit);
      int          x;
      int          y;
      int          xdraw;
      int          ydraw;
      int          count;
      int          m;
      int          k;
      rsp_type     cmd;
      rsp_type     cmds[$];
      if (e.code_word == 16'h0000) return 0;
      if (e.attr_y_word[AY_FLASH_BIT] && odd) return 0;
      count = 1 << e.attr_y_word[10:9];
      x = int'(e.attr_x_word[8:0]);
      y = int'(e.attr_y_word[8:0]);
      if (x >= X_WRAP_LIMIT) x = x - WRAP_SPAN;
      if (y >= Y_WRAP_LIMIT) y = y - WRAP_SPAN;
      x = X_MIRROR - x;
      y = Y_MIRROR - y;
      xdraw = x + BORDER + x_shift;
      if (xdraw <= BORDER - TILE_SIZE || xdraw >= VIS_W + BORDER) return 0;
      // walk from the top tile down, skipping rows off screen
      for (k = 0; k < count; k++) begin
         m = count - 1 - k;
         ydraw = y - TILE_SIZE * m + BORDER - Y_ALIGN + y_shift;
         if (ydraw > BORDER - TILE_SIZE && ydraw < VIS_H + BORDER) begin
            cmd.tile_code = 16'(e.code_word + (e.attr_y_word[AY_FLIPY_BIT] ? m : k));
            cmd.screen_x  = 9'(xdraw);
            cmd.screen_y  = 8'(ydraw);
            cmd.colour    = e.attr_x_word[12:9];
            cmd.flip      = e.attr_y_word[AY_FLIPY_BIT:AY_FLIPX_BIT];
            cmd.last      = 1'b0;
            cmds.push_back(cmd);
         end
      end
      if (cmds.size() != 0) cmds[cmds.size() - 1].last = 1'b1;
      if (commit) begin
         foreach (cmds[i]) tile_cmds_due.push_back(cmds[i]);
      end
      return cmds.size();
   endfunction

   // idle length for one transaction, with stretches of none
   function automatic int unsigned draw_wait(inout int unsigned calm);
      if (calm != 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm = $urandom_range(8, 24);
         return 0;
      end
      return $urandom_range(0, 16);
   endfunction

   function automatic req_type pack_entry(input bit sol, input int unsigned y,
                                          input height_code_type h, input bit flash,
                                          input flip_type fl, input logic [15:0] code,
                                          input int unsigned x, input int unsigned colour);
      req_type e;
      e.start_of_list = sol;
      e.attr_y_word   = {1'b0, fl, flash, 1'b0, h, 9'(y)};
      e.code_word     = code;
      e.attr_x_word   = {3'b000, 4'(colour), 9'(x)};
      return e;
   endfunction

   function automatic req_type random_entry();
      req_type e;
      if ($urandom_range(0, 3) == 0) begin
         // noise: any bit pattern, often an unused entry
         e.start_of_list = 1'($urandom);
         e.attr_y_word   = 16'($urandom);
         e.code_word     = ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom);
         e.attr_x_word   = 16'($urandom);
      end else begin
         // mostly on screen, sometimes wrapped or near the code wrap
         e = pack_entry($urandom_range(0, 7) == 0,
                        ($urandom_range(0, 9) == 0) ? $urandom_range(256, 511)
                                                    : $urandom_range(0, 255),
                        height_code_type'($urandom_range(0, 3)),
                        $urandom_range(0, 3) == 0,
                        flip_type'($urandom_range(0, 3)),
                        ($urandom_range(0, 15) == 0) ? 16'($urandom_range(16'hfff8, 16'hffff))
                                                     : 16'($urandom_range(1, 16'hffff)),
                        ($urandom_range(0, 9) == 0) ? $urandom_range(320, 511)
                                                    : $urandom_range(0, 319),
                        $urandom_range(0, 15));
         e.attr_y_word[15]    = 1'($urandom);
         e.attr_y_word[11]    = 1'($urandom);
         e.attr_x_word[15:13] = 3'($urandom);
      end
      return e;
   endfunction

   // hand an entry to the source side; returns the tiles it should give
   function automatic int queue_entry(input req_type e, input bit drain_first);
      entry_slot_type slot;
      if (e.start_of_list) gen_odd_frame = ~gen_odd_frame;
      slot.entry       = e;
      slot.gap         = draw_wait(source_calm);
      slot.drain_first = drain_first;
      pending_entries.push_back(slot);
      entries_queued++;
      return expand_entry(e, gen_odd_frame, 1'b0);
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_SPRITE_X_OFFSET: x_shift = $signed(value);
         CSR_SPRITE_Y_OFFSET: y_shift = $signed(value);
         default: ;
      endcase
   endtask

   // wait for every entry taken and every tile command seen, then let the walk end
   task automatic settle();
      do @(posedge clock);
      while (entries_taken != entries_queued || tile_cmds_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_random(input int unsigned tiled_entries);
      int unsigned productive;
      bit          drain;
      productive = 0;
      while (productive < tiled_entries) begin
         drain = (productive == tiled_entries / 2) || ($urandom_range(0, 29) == 0);
         if (queue_entry(random_entry(), drain) > 0) productive++;
      end
   endtask

   // source side: present queued entries, predict each accepted transaction
   always @(posedge clock) begin : source_proc
      bit slot_free;
      if (reset) begin
         req_valid <= 1'b0;
         odd_frame = 1'b0;
      end else begin
         slot_free = !req_valid;
         if (req_valid && req_ready) begin
            if (req_data.start_of_list) odd_frame = ~odd_frame;
            void'(expand_entry(req_data, odd_frame, 1'b1));
            entries_taken++;
            slot_free = 1'b1;
         end
         if (slot_free) begin
            if (!staged && pending_entries.size() != 0) begin
               staged_slot = pending_entries.pop_front();
               staged      = 1'b1;
               hold_left   = staged_slot.gap;
            end
            if (staged && hold_left != 0) begin
               hold_left--;
               req_valid <= 1'b0;
            end else if (staged && (!staged_slot.drain_first || tile_cmds_due.size() == 0)) begin
               req_valid <= 1'b1;
               req_data  <= staged_slot.entry;
               staged     = 1'b0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result side: random stalls, compare each transaction with the oldest prediction
   always @(posedge clock) begin : sink_proc
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (tile_cmds_due.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("unexpected tile command: code %h x %0d y %0d last %0d",
                           rsp_data.tile_code, rsp_data.screen_x, rsp_data.screen_y,
                           rsp_data.last);
            end else begin
               want = tile_cmds_due.pop_front();
               if (rsp_data.tile_code !== want.tile_code || rsp_data.screen_x !== want.screen_x ||
                   rsp_data.screen_y !== want.screen_y || rsp_data.colour !== want.colour ||
                   rsp_data.flip !== want.flip || rsp_data.last !== want.last) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT)
                     $display({"tile command mismatch: expected code %h x %0d y %0d color %0d ",
                               "flip %0d last %0d, got code %h x %0d y %0d color %0d ",
                               "flip %0d last %0d"},
                              want.tile_code, want.screen_x, want.screen_y, want.colour,
                              want.flip, want.last, rsp_data.tile_code, rsp_data.screen_x,
                              rsp_data.screen_y, rsp_data.colour, rsp_data.flip,
                              rsp_data.last);
               end
            end
            stall_left = draw_wait(sink_calm);
         end else if (rsp_valid && stall_left != 0) begin
            stall_left--;
         end
         rsp_ready <= (stall_left == 0);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed entries under the reset offsets
      void'(queue_entry(pack_entry(1'b1, 0, HEIGHT_1, 1'b0, FLIP_NONE, 16'h0000, 0, 0), 1'b0));
      void'(queue_entry('0, 1'b0));
      // flashing on an odd frame, then shown again on the next even frame
      void'(queue_entry(pack_entry(1'b0, 0, HEIGHT_1, 1'b1, FLIP_NONE, 16'h0001, 0, 0), 1'b0));
      void'(queue_entry(pack_entry(1'b1, 100, HEIGHT_1, 1'b1, FLIP_X, 16'h1234, 100, 5),
                        1'b0));
      // every height, y flip and code wrap
      void'(queue_entry(pack_entry(1'b0, 0, HEIGHT_2, 1'b0, FLIP_NONE, 16'h0100, 0, 15), 1'b0));
      void'(queue_entry(pack_entry(1'b0, 0, HEIGHT_4, 1'b0, FLIP_Y, 16'h0200, 50, 3), 1'b0));
      void'(queue_entry(pack_entry(1'b0, 0, HEIGHT_8, 1'b0, FLIP_NONE, 16'hfffe, 160, 7), 1'b0));
      void'(queue_entry(pack_entry(1'b0, 0, HEIGHT_8, 1'b0, FLIP_XY, 16'hfffc, 160, 9), 1'b0));
      // vertical clip: top rows gone, bottom row gone, single tile just inside and just outside the top edge
      void'(queue_entry(pack_entry(1'b0, 200, HEIGHT_8, 1'b0, FLIP_NONE, 16'h0400, 10, 1),
                        1'b0));
      void'(queue_entry(pack_entry(1'b0, 505, HEIGHT_2, 1'b0, FLIP_Y, 16'h0500, 10, 2), 1'b0));
      void'(queue_entry(pack_entry(1'b0, 248, HEIGHT_1, 1'b0, FLIP_NONE, 16'h0600, 20, 0),
                        1'b0));
      void'(queue_entry(pack_entry(1'b0, 249, HEIGHT_1, 1'b0, FLIP_NONE, 16'h0700, 20, 0),
                        1'b0));
      // horizontal clip on both edges and across the wrap
      void'(queue_entry(pack_entry(1'b0, 50, HEIGHT_1, 1'b0, FLIP_NONE, 16'h0800, 315, 4),
                        1'b0));
      void'(queue_entry(pack_entry(1'b0, 50, HEIGHT_1, 1'b0, FLIP_NONE, 16'h0801, 316, 4),
                        1'b0));
      void'(queue_entry(pack_entry(1'b0, 50, HEIGHT_1, 1'b0, FLIP_NONE, 16'h0802, 493, 4),
                        1'b0));
      void'(queue_entry(pack_entry(1'b0, 50, HEIGHT_1, 1'b0, FLIP_NONE, 16'h0803, 492, 4),
                        1'b0));
      void'(queue_entry(pack_entry(1'b0, 50, HEIGHT_1, 1'b0, FLIP_NONE, 16'h0804, 320, 4),
                        1'b0));
      void'(queue_entry(pack_entry(1'b0, 50, HEIGHT_4, 1'b0, FLIP_NONE, 16'h0805, 511, 4),
                        1'b0));
      // ignored bits set, all ones on an odd frame and on an even frame
      void'(queue_entry(req_type'{1'b0, 16'ha8f0, 16'h0042, 16'he864}, 1'b0));
      void'(queue_entry(req_type'{1'b1, 16'hffff, 16'hffff, 16'hffff}, 1'b0));
      void'(queue_entry(req_type'{1'b0, 16'hffff, 16'hffff, 16'hffff}, 1'b0));
      void'(queue_entry(req_type'{1'b1, 16'hffff, 16'hffff, 16'hffff}, 1'b0));
      settle();

      // offsets at opposite extremes
      write_reg(CSR_SPRITE_X_OFFSET, 5'b01111);
      write_reg(CSR_SPRITE_Y_OFFSET, 5'b10000);
      queue_random(25);
      settle();

      write_reg(CSR_SPRITE_X_OFFSET, 5'b10000);
      write_reg(CSR_SPRITE_Y_OFFSET, 5'b01111);
      queue_random(25);
      settle();

      // writes to the spare indexes must leave the offsets alone
      write_reg(CSR_SPRITE_X_OFFSET, 5'b00000);
      write_reg(CSR_SPRITE_Y_OFFSET, 5'b11111);
      write_reg(CSR_SPARE_2, 5'b01010);
      write_reg(CSR_SPARE_3, 5'b00111);
      queue_random(25);
      settle();

      write_reg(CSR_SPRITE_X_OFFSET, 5'($urandom_range(0, 31)));
      write_reg(CSR_SPRITE_Y_OFFSET, 5'($urandom_range(0, 31)));
      queue_random(25);
      settle();

      if (error_count == 0 && tile_cmds_due.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
